// ===== hw/rtl/dge_pkg.sv =====
// dge_pkg: shared constants, register indexes and mode codes for the
// depth-to-gray encoder. No dependencies; compiled first.
package dge_pkg;

   // configuration register indexes
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CSR_MODE = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_MAX  = 1'b1;

   // encoding modes
   localparam logic [1:0] MODE_LEGACY = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_LOG    = 2'd2;
   localparam logic [1:0] MODE_INV    = 2'd3;

   // fixed-point constants
   localparam logic [31:0] MAX_RESET = 32'd65536000;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam logic [16:0] Q16_ONE   = 17'h10000;
   localparam logic [23:0] CHAN_MAX  = 24'hFFFFFF;

   // log unit: msb stage, normalize stage, one stage per fraction bit
   localparam int LogFracW = 24;
   localparam int LogW     = 30;
   localparam int LogLat   = LogFracW + 2;
   localparam logic [LogW-1:0] LOG_BASE = 30'h1000000 << 4;

   // divider: 17 quotient bits, one per stage
   localparam int NumW   = 48;
   localparam int DenW   = 33;
   localparam int QuoW   = 17;
   localparam int DivLat = QuoW;

endpackage

// ===== hw/rtl/dge_req_if.sv =====
// dge_req_if: ray sample channel (valid/ready plus sample fields).
// No dependencies.
interface dge_req_if;
   logic        valid;
   logic        ready;
   logic        hit_found;
   logic [31:0] hit_distance;
   logic [16:0] sample_weight;
   logic [23:0] prior_red;
   logic [23:0] prior_green;
   logic [23:0] prior_blue;

   modport source (output valid, hit_found, hit_distance, sample_weight,
                   prior_red, prior_green, prior_blue, input ready);
   modport sink   (input valid, hit_found, hit_distance, sample_weight,
                   prior_red, prior_green, prior_blue, output ready);
endinterface

// ===== hw/rtl/dge_rsp_if.sv =====
// dge_rsp_if: shaded result channel (valid/ready plus color and depth).
// No dependencies.
interface dge_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] out_red;
   logic [23:0] out_green;
   logic [23:0] out_blue;
   logic [16:0] encoded_depth;

   modport source (output valid, out_red, out_green, out_blue, encoded_depth,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, encoded_depth,
                   output ready);
endinterface

// ===== hw/rtl/depth_to_gray_encoder.sv =====
// depth_to_gray_encoder: top level of the per-sample depth shader pipeline.
// Depends on dge_pkg, dge_req_if, dge_rsp_if, dge_log2, dge_div.
//
// Usage:
//   req carries one ray sample per transfer; rsp carries one shaded result
//   per sample, in order. csr_we/csr_index/csr_wdata write the encoding
//   mode (index 0) and far clip distance (index 1); write only while idle.
//   Throughput: one sample per cycle while rsp is not stalled. The depth is
//   set by the 26-stage log unit (one squaring per fraction bit) and the
//   17-stage divider (one quotient bit per stage).
//   Every stage holds a valid bit; a stall of rsp freezes the pipeline
//   only once a result waits in the output register and the last stage is
//   occupied, so an empty last stage is still filled while rsp stalls.
//   Reset (synchronous, active high) drops all items in flight and sets
//   mode to legacy and the far clip to 1000.0.
module depth_to_gray_encoder (
   input  logic                         clock,
   input  logic                         reset,
   dge_req_if.sink                      req,
   dge_rsp_if.source                    rsp,
   input  logic                         csr_we,
   input  logic [dge_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [31:0]                  csr_wdata
);
   import dge_pkg::*;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic [1:0]  mode;
      logic [31:0] hit_dist;
      logic [16:0] weight;
      logic [23:0] red;
      logic [23:0] green;
      logic [23:0] blue;
      logic [NumW-1:0] lin_num;
   } side_type;

   typedef struct packed {
      side_type        side;
      logic [DenW-1:0] va;
      logic [DenW-1:0] vb;
   } prep_type;

   typedef struct packed {
      side_type        side;
      logic [LogW-1:0] ld;
      logic [LogW-1:0] lm;
      logic [59:0]     lnp;
   } post_log_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic        forced;
      logic        negate;
      logic [16:0] fval;
      logic [16:0] weight;
      logic [23:0] red;
      logic [23:0] green;
      logic [23:0] blue;
   } ctl_type;

   typedef struct packed {
      ctl_type         ctl;
      logic [NumW-1:0] num;
      logic [DenW-1:0] den;
   } div_in_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic [16:0] enc;
      logic [16:0] weight;
      logic [23:0] red;
      logic [23:0] green;
      logic [23:0] blue;
   } enc_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic [16:0] enc;
      logic [33:0] prod;
      logic [23:0] red;
      logic [23:0] green;
      logic [23:0] blue;
   } mul_type;

   logic [1:0]      mode_ff;
   logic [31:0]     max_ff;
   logic [31:0]     max_eff;
   logic            adv;
   logic            load_out;

   side_type        s0_ff;
   side_type        s0_in;
   prep_type        s1_ff;
   prep_type        s1_in;
   side_type        sd_ff [1:LogLat];
   logic [LogW-1:0] log_a;
   logic [LogW-1:0] log_b;
   post_log_type    p1_ff;
   post_log_type    p1_in;
   div_in_type      p2_ff;
   div_in_type      p2_in;
   ctl_type         dd_ff [1:DivLat];
   logic [QuoW-1:0] quo;
   enc_type         f_ff;
   enc_type         f_in;
   mul_type         m_ff;
   mul_type         m_in;

   logic            out_valid_ff;
   logic [23:0]     out_red_ff;
   logic [23:0]     out_green_ff;
   logic [23:0]     out_blue_ff;
   logic [16:0]     out_enc_ff;
   logic [24:0]     gray_sum;
   logic [23:0]     gray;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LEGACY;
         max_ff  <= MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE: mode_ff <= csr_wdata[1:0];
            CSR_MAX:  max_ff  <= csr_wdata;
            default:  ;
         endcase
      end
   end

   // a zero far clip counts as the smallest step
   assign max_eff = (max_ff == '0) ? 32'd1 : max_ff;

   // pipeline moves unless a result waits and the last stage is full
   assign load_out  = !out_valid_ff || rsp.ready;
   assign adv       = load_out || !m_ff.valid;
   assign req.ready = adv;

   // input capture
   always_comb begin
      s0_in          = '0;
      s0_in.valid    = req.valid;
      s0_in.hit      = req.hit_found;
      s0_in.mode     = mode_ff;
      s0_in.hit_dist = req.hit_distance;
      s0_in.weight   = req.sample_weight;
      s0_in.red      = req.prior_red;
      s0_in.green    = req.prior_green;
      s0_in.blue     = req.prior_blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ff <= s0_in;
      end
   end

   // clamp distance, build linear numerator and log operands
   always_comb begin
      logic [31:0] dm;
      dm                   = (s0_ff.hit_dist < max_eff) ? s0_ff.hit_dist : max_eff;
      s1_in.side           = s0_ff;
      s1_in.side.lin_num   = NumW'({max_eff - dm, 16'd0});
      s1_in.va             = (s0_ff.mode == MODE_LOG) ? DenW'(dm) + DenW'(Q16_ONE)
                                                      : DenW'(s0_ff.hit_dist);
      s1_in.vb             = DenW'(max_eff) + DenW'(Q16_ONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.side.valid <= 1'b0;
      end else if (adv) begin
         s1_ff <= s1_in;
      end
   end

   // log units for the sample and for the far clip
   dge_log2 u_log_a (
      .clock (clock),
      .en    (adv),
      .v     (s1_ff.va),
      .log_q (log_a)
   );

   dge_log2 u_log_b (
      .clock (clock),
      .en    (adv),
      .v     (s1_ff.vb),
      .log_q (log_b)
   );

   // side data delayed alongside the log units
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= LogLat; i++) begin
            sd_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         sd_ff[1] <= s1_ff.side;
         for (int i = 2; i <= LogLat; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   // remove the 2^16 offset, scale legacy log by ln 2
   always_comb begin
      p1_in.side = sd_ff[LogLat];
      p1_in.ld   = log_a - LOG_BASE;
      p1_in.lm   = log_b - LOG_BASE;
      p1_in.lnp  = 60'(p1_in.ld[27:0]) * 60'(LN2_Q32);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.side.valid <= 1'b0;
      end else if (adv) begin
         p1_ff <= p1_in;
      end
   end

   // select divider operands or a fixed result per mode
   always_comb begin
      logic [27:0] ln;
      ln                  = p1_ff.lnp[59:32];
      p2_in.ctl.valid     = p1_ff.side.valid;
      p2_in.ctl.hit       = p1_ff.side.hit;
      p2_in.ctl.weight    = p1_ff.side.weight;
      p2_in.ctl.red       = p1_ff.side.red;
      p2_in.ctl.green     = p1_ff.side.green;
      p2_in.ctl.blue      = p1_ff.side.blue;
      p2_in.ctl.forced    = 1'b0;
      p2_in.ctl.negate    = 1'b0;
      p2_in.ctl.fval      = '0;
      p2_in.num           = '0;
      p2_in.den           = DenW'(1);
      case (p1_ff.side.mode)
         MODE_LINEAR: begin
            p2_in.num = p1_ff.side.lin_num;
            p2_in.den = DenW'(max_eff);
         end
         MODE_LOG: begin
            if (p1_ff.ld >= p1_ff.lm) begin
               p2_in.ctl.forced = 1'b1;
            end else begin
               p2_in.num        = NumW'({p1_ff.ld, 16'd0});
               p2_in.den        = DenW'(p1_ff.lm);
               p2_in.ctl.negate = 1'b1;
            end
         end
         MODE_INV: begin
            p2_in.num = NumW'(1) << 32;
            p2_in.den = DenW'(p1_ff.side.hit_dist) + DenW'(Q16_ONE);
         end
         default: begin
            // short distance or tiny log saturates at one
            if (p1_ff.side.hit_dist <= 32'(Q16_ONE) || ln <= 28'h1000000) begin
               p2_in.ctl.forced = 1'b1;
               p2_in.ctl.fval   = Q16_ONE;
            end else begin
               p2_in.num = NumW'(1) << 40;
               p2_in.den = DenW'(ln);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ff.ctl.valid <= 1'b0;
      end else if (adv) begin
         p2_ff <= p2_in;
      end
   end

   dge_div u_div (
      .clock (clock),
      .en    (adv),
      .num   (p2_ff.num),
      .den   (p2_ff.den),
      .quo   (quo)
   );

   // control delayed alongside the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= DivLat; i++) begin
            dd_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         dd_ff[1] <= p2_ff.ctl;
         for (int i = 2; i <= DivLat; i++) begin
            dd_ff[i] <= dd_ff[i-1];
         end
      end
   end

   // final encoding
   always_comb begin
      f_in.valid  = dd_ff[DivLat].valid;
      f_in.hit    = dd_ff[DivLat].hit;
      f_in.weight = dd_ff[DivLat].weight;
      f_in.red    = dd_ff[DivLat].red;
      f_in.green  = dd_ff[DivLat].green;
      f_in.blue   = dd_ff[DivLat].blue;
      if (!dd_ff[DivLat].hit) begin
         f_in.enc = '0;
      end else if (dd_ff[DivLat].forced) begin
         f_in.enc = dd_ff[DivLat].fval;
      end else if (dd_ff[DivLat].negate) begin
         f_in.enc = Q16_ONE - quo;
      end else begin
         f_in.enc = quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff.valid <= 1'b0;
      end else if (adv) begin
         f_ff <= f_in;
      end
   end

   // weight the encoding
   always_comb begin
      m_in.valid = f_ff.valid;
      m_in.hit   = f_ff.hit;
      m_in.enc   = f_ff.enc;
      m_in.prod  = 34'(f_ff.enc) * 34'(f_ff.weight);
      m_in.red   = f_ff.red;
      m_in.green = f_ff.green;
      m_in.blue  = f_ff.blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff.valid <= 1'b0;
      end else if (adv) begin
         m_ff <= m_in;
      end
   end

   // saturating gray sum
   assign gray_sum = 25'(m_ff.red) + 25'(m_ff.prod[33:16]);
   assign gray     = gray_sum[24] ? CHAN_MAX : gray_sum[23:0];

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= m_ff.valid;
         out_red_ff   <= m_ff.hit ? gray : m_ff.red;
         out_green_ff <= m_ff.hit ? gray : m_ff.green;
         out_blue_ff  <= m_ff.hit ? gray : m_ff.blue;
         out_enc_ff   <= m_ff.enc;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.out_red       = out_red_ff;
   assign rsp.out_green     = out_green_ff;
   assign rsp.out_blue      = out_blue_ff;
   assign rsp.encoded_depth = out_enc_ff;

endmodule

// ===== hw/rtl/dge_log2.sv =====
// dge_log2: pipelined base-2 logarithm, Q.24 result, by repeated squaring.
// Depends on dge_pkg.
module dge_log2 (
   input  logic                      clock,
   input  logic                      en,
   input  logic [dge_pkg::DenW-1:0]  v,
   output logic [dge_pkg::LogW-1:0]  log_q
);
   import dge_pkg::*;

   logic [DenW-1:0]     v_ff;
   logic [5:0]          e0_ff;
   logic [5:0]          msb_in;
   logic [DenW+29:0]    norm_in;
   logic [30:0]         m_ff  [0:LogFracW];
   logic [LogFracW-1:0] fr_ff [0:LogFracW];
   logic [5:0]          e_ff  [0:LogFracW];

   // msb position of the operand
   always_comb begin
      msb_in = '0;
      for (int i = 1; i < DenW; i++) begin
         if (v[i]) begin
            msb_in = 6'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff  <= v;
         e0_ff <= msb_in;
      end
   end

   // normalize mantissa to Q1.30
   assign norm_in = {v_ff, 30'd0} >> e0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]  <= norm_in[30:0];
         fr_ff[0] <= '0;
         e_ff[0]  <= e0_ff;
      end
   end

   // one fraction bit per stage: square, then halve on overflow past 2.0
   for (genvar k = 0; k < LogFracW; k++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      assign sq = 62'(m_ff[k]) * 62'(m_ff[k]);
      assign t  = sq[61:30];
      always_ff @(posedge clock) begin
         if (en) begin
            if (t[31]) begin
               m_ff[k+1]  <= t[31:1];
               fr_ff[k+1] <= {fr_ff[k][LogFracW-2:0], 1'b1};
            end else begin
               m_ff[k+1]  <= t[30:0];
               fr_ff[k+1] <= {fr_ff[k][LogFracW-2:0], 1'b0};
            end
            e_ff[k+1] <= e_ff[k];
         end
      end
   end

   assign log_q = {e_ff[LogFracW], fr_ff[LogFracW]};

endmodule

// ===== hw/rtl/dge_div.sv =====
// dge_div: pipelined restoring divider, one quotient bit per stage.
// Depends on dge_pkg. Quotient must fit in QuoW bits.
module dge_div (
   input  logic                      clock,
   input  logic                      en,
   input  logic [dge_pkg::NumW-1:0]  num,
   input  logic [dge_pkg::DenW-1:0]  den,
   output logic [dge_pkg::QuoW-1:0]  quo
);
   import dge_pkg::*;

   logic [DenW-1:0] rem_ff [1:QuoW];
   logic [QuoW-1:0] nl_ff  [1:QuoW];
   logic [DenW-1:0] dn_ff  [1:QuoW];
   logic [QuoW-1:0] q_ff   [1:QuoW];

   for (genvar k = 0; k < QuoW; k++) begin : g_step
      logic [DenW-1:0] rem_c;
      logic [DenW-1:0] den_c;
      logic [QuoW-1:0] nl_c;
      logic [QuoW-1:0] q_c;
      logic [DenW:0]   trial;

      if (k == 0) begin : g_first
         assign rem_c = DenW'(num[NumW-1:QuoW]);
         assign nl_c  = num[QuoW-1:0];
         assign den_c = den;
         assign q_c   = '0;
      end else begin : g_next
         assign rem_c = rem_ff[k];
         assign nl_c  = nl_ff[k];
         assign den_c = dn_ff[k];
         assign q_c   = q_ff[k];
      end

      // bring down next numerator bit, subtract when it fits
      assign trial = {rem_c, nl_c[QuoW-1-k]};

      always_ff @(posedge clock) begin
         if (en) begin
            if (trial >= {1'b0, den_c}) begin
               rem_ff[k+1] <= DenW'(trial - {1'b0, den_c});
               q_ff[k+1]   <= {q_c[QuoW-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= trial[DenW-1:0];
               q_ff[k+1]   <= {q_c[QuoW-2:0], 1'b0};
            end
            nl_ff[k+1] <= nl_c;
            dn_ff[k+1] <= den_c;
         end
      end
   end

   assign quo = q_ff[QuoW];

endmodule

// ===== hw/rtl/dge_checker.sv =====
// dge_checker: port-level checks of the depth-to-gray encoder result channel,
// bound to the top level. Depends on depth_to_gray_encoder.
module dge_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] out_red,
   input logic [23:0] out_green,
   input logic [23:0] out_blue,
   input logic [16:0] encoded_depth
);

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({out_red, out_green, out_blue, encoded_depth}))
      else $error("stalled result changed");

   // encoding never exceeds one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> encoded_depth <= 17'h10000)
      else $error("encoded depth above one");

   // a nonzero encoding only comes from a hit, which writes gray
   a_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && encoded_depth != 17'd0 |->
      out_red == out_green && out_green == out_blue)
      else $error("hit result is not gray");

   // reset empties the pipeline
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind depth_to_gray_encoder dge_checker u_dge_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .out_red       (rsp.out_red),
   .out_green     (rsp.out_green),
   .out_blue      (rsp.out_blue),
   .encoded_depth (rsp.encoded_depth)
);

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for depth_to_gray_encoder, with random gaps and stalls
// on both channels and an in-bench shading predictor.
// Depends on dge_pkg, dge_req_if, dge_rsp_if and the encoder RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dge_pkg::*;

   typedef struct {
      logic        hit;
      logic [31:0] hit_dist;
      logic [16:0] weight;
      logic [23:0] red;
      logic [23:0] green;
      logic [23:0] blue;
   } sample_type;

   typedef struct {
      logic [23:0] red;
      logic [23:0] green;
      logic [23:0] blue;
      logic [16:0] depth;
   } shade_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [31:0] csr_wdata;

   dge_req_if req ();
   dge_rsp_if rsp ();

   depth_to_gray_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bench copy of the configuration
   logic [1:0]  cfg_mode;
   logic [31:0] cfg_max;

   sample_type samples_pending[$];
   shade_type  shades_expected[$];
   int      send_gap;
   int      recv_stall;
   int      recv_hold;
   bit      no_idle;
   int      mismatches;
   int      shades_seen;
   int      hits_sent;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // log2 in Q.24 by repeated squaring, truncated
   function automatic logic [63:0] log2_q24(logic [63:0] v);
      int unsigned msb;
      logic [63:0] mant;
      logic [63:0] frac;
      msb = 0;
      frac = 0;
      if (v == 0) return 0;
      for (int i = 0; i < 64; i++) if (v[i]) msb = i;
      mant = (msb > 30) ? (v >> (msb - 30)) : (v << (30 - msb));
      for (int i = 0; i < LogFracW; i++) begin
         mant = (mant * mant) >> 30;
         frac = frac << 1;
         if (mant >= (64'd2 << 30)) begin
            mant = mant >> 1;
            frac = frac | 1;
         end
      end
      return (64'(msb) << LogFracW) | frac;
   endfunction

   // depth encoding for the current mode and far clip
   function automatic logic [63:0] depth_code(logic [63:0] d);
      logic [63:0] m;
      logic [63:0] dm;
      logic [63:0] ld;
      logic [63:0] lm;
      logic [63:0] ratio;
      logic [63:0] code;
      m = (cfg_max == 0) ? 64'd1 : 64'(cfg_max);
      dm = (d < m) ? d : m;
      case (cfg_mode)
         MODE_LINEAR: begin
            code = ((m - dm) * 64'd65536) / m;
         end
         MODE_LOG: begin
            ld = log2_q24(64'd65536 + dm) - (64'd16 << LogFracW);
            lm = log2_q24(64'd65536 + m) - (64'd16 << LogFracW);
            if (lm == 0) code = 0;
            else begin
               ratio = (ld * 64'd65536) / lm;
               code = (ratio >= 64'd65536) ? 64'd0 : 64'd65536 - ratio;
            end
         end
         MODE_INV: begin
            code = (64'd1 << 32) / (64'd65536 + d);
         end
         default: begin
            if (d <= 64'd65536) code = 64'd65536;
            else begin
               ld = log2_q24(d) - (64'd16 << LogFracW);
               lm = (ld * 64'(LN2_Q32)) >> 32;
               code = (lm == 0) ? 64'd65536 : (64'd1 << 40) / lm;
            end
         end
      endcase
      if (code > 64'd65536) code = 64'd65536;
      return code;
   endfunction

   // expected shaded result of one sample
   function automatic shade_type shade_sample(sample_type s);
      shade_type r;
      logic [63:0] code;
      logic [63:0] gray;
      r.red = s.red;
      r.green = s.green;
      r.blue = s.blue;
      r.depth = '0;
      if (s.hit) begin
         code = depth_code(64'(s.hit_dist));
         gray = 64'(s.red) + ((code * 64'(s.weight)) >> 16);
         if (gray > 64'(CHAN_MAX)) gray = 64'(CHAN_MAX);
         r.red = gray[23:0];
         r.green = gray[23:0];
         r.blue = gray[23:0];
         r.depth = code[16:0];
      end
      return r;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   // sample driver: one transfer per handshake, gap drawn per sample
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req.valid && req.ready) begin
            shades_expected.push_back(shade_sample('{req.hit_found, req.hit_distance,
               req.sample_weight, req.prior_red, req.prior_green, req.prior_blue}));
            if (req.hit_found) hits_sent <= hits_sent + 1;
         end
         if (!req.valid || req.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req.valid <= 1'b0;
            end else if (samples_pending.size() > 0) begin
               sample_type s;
               s = samples_pending.pop_front();
               req.valid <= 1'b1;
               req.hit_found <= s.hit;
               req.hit_distance <= s.hit_dist;
               req.sample_weight <= s.weight;
               req.prior_red <= s.red;
               req.prior_green <= s.green;
               req.prior_blue <= s.blue;
               send_gap <= draw_gap();
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off countdown
   always @(posedge clock) begin
      if (!reset && recv_hold > 0) recv_hold <= recv_hold - 1;
   end

   // result monitor: random stalls, one long hold-off, field checks
   always @(posedge clock) begin
      int gap;
      gap = 0;
      if (reset) begin
         rsp.ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            shades_seen <= shades_seen + 1;
            if (shades_expected.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result transfer");
            end else begin
               shade_type e;
               e = shades_expected.pop_front();
               if (rsp.out_red !== e.red || rsp.out_green !== e.green ||
                   rsp.out_blue !== e.blue || rsp.encoded_depth !== e.depth) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: exp rgb %h %h %h depth %h, got %h %h %h depth %h",
                        e.red, e.green, e.blue, e.depth, rsp.out_red, rsp.out_green,
                        rsp.out_blue, rsp.encoded_depth);
               end
            end
            gap = draw_gap();
            recv_stall <= (gap > 0) ? gap - 1 : 0;
            rsp.ready <= (gap == 0) && (recv_hold == 0);
         end else if (recv_hold > 0) begin
            rsp.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   function automatic sample_type random_sample();
      sample_type s;
      s.hit = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
         0: s.hit_dist = $urandom();
         1: s.hit_dist = $urandom_range(0, 32'h0010_0000);
         2: s.hit_dist = cfg_max + $urandom_range(0, 64) - 32;
         default: s.hit_dist = $urandom_range(0, 32'h0400_0000);
      endcase
      s.weight = ($urandom_range(0, 7) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536));
      s.red = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(24'hFF0000, 24'hFFFFFF))
                                          : 24'($urandom());
      s.green = 24'($urandom());
      s.blue = 24'($urandom());
      return s;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (samples_pending.size() != 0 || req.valid || shades_expected.size() != 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // stimulus: phases over modes and far clips
   initial begin
      logic [31:0] far_clip[8];
      logic [31:0] dists[6];
      req.valid = 1'b0;
      req.hit_found = 1'b0;
      req.hit_distance = '0;
      req.sample_weight = '0;
      req.prior_red = '0;
      req.prior_green = '0;
      req.prior_blue = '0;
      rsp.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_MODE;
      csr_wdata = '0;
      cfg_mode = MODE_LEGACY;
      cfg_max = MAX_RESET;
      recv_hold = 0;
      no_idle = 1'b0;
      mismatches = 0;
      shades_seen = 0;
      hits_sent = 0;
      far_clip = '{MAX_RESET, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000, $urandom(),
                   $urandom_range(1, 32'h0010_0000), $urandom(), 32'd1};
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 8; ph++) begin
         if (ph > 0) begin
            wait_drained();
            cfg_mode = 2'(ph % 4);
            cfg_max = far_clip[ph];
            write_reg(CSR_MODE, 32'(cfg_mode));
            write_reg(CSR_MAX, cfg_max);
         end
         no_idle = (ph % 3 == 1);
         // long receiver hold-off so the pipeline fills and backs up
         if (ph == 2) recv_hold = 400;
         // directed extremes, legacy knee and misses
         if (ph < 4) begin
            dists = '{32'd0, 32'h0001_0000, 32'h0001_0001, 32'hFFFF_FFFF, cfg_max,
                      32'h0001_0002};
            foreach (dists[k])
               samples_pending.push_back('{1'b1, dists[k],
                  (k % 3 == 0) ? 17'h1FFFF : ((k % 3 == 1) ? Q16_ONE : 17'd0),
                  (k % 2 == 0) ? CHAN_MAX : 24'd0, 24'd0, CHAN_MAX});
         end
         if (ph == 0)
            samples_pending.push_back('{1'b0, 32'hFFFF_FFFF, 17'h1FFFF, CHAN_MAX,
                                       24'h0, CHAN_MAX});
         for (int k = 0; k < 68; k++) samples_pending.push_back(random_sample());
      end
      wait_drained();
      $display("covered 4 encoding modes over 8 far-clip settings, %0d results, %0d hits",
               shades_seen, hits_sent);
      if (mismatches == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
